// ----- src/smrd_pkg.sv -----
// smrd_pkg: shared types, constants and gain table of the stereo reflection delay core
// depends on nothing; imported by the register block, the tap accumulator and the top level

package smrd_pkg;

  // configuration register map
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;
  localparam int DELAY_W  = 10;
  localparam int CFG_TAPS = 5;
  localparam int MAX_TAPS = 8;
  localparam int TAP_IDX_W = 3;
  localparam int GAIN_W   = 16;
  localparam int FRAC_W   = 15;

  localparam logic [2:0] REG_ENABLE      = 3'd0;
  localparam logic [2:0] REG_DELAY_ONE   = 3'd1;
  localparam logic [2:0] REG_DELAY_TWO   = 3'd2;
  localparam logic [2:0] REG_DELAY_THREE = 3'd3;
  localparam logic [2:0] REG_DELAY_FOUR  = 3'd4;
  localparam logic [2:0] REG_DELAY_FIVE  = 3'd5;

  localparam logic [DELAY_W-1:0] DELAY_ONE_RST   = 10'd57;
  localparam logic [DELAY_W-1:0] DELAY_TWO_RST   = 10'd100;
  localparam logic [DELAY_W-1:0] DELAY_THREE_RST = 10'd144;
  localparam logic [DELAY_W-1:0] DELAY_FOUR_RST  = 10'd206;
  localparam logic [DELAY_W-1:0] DELAY_FIVE_RST  = 10'd264;

  // live configuration seen by the datapath
  typedef struct packed {
    logic                              enable;
    logic [CFG_TAPS-1:0][DELAY_W-1:0]  delay;
  } cfg_t;

  // control for one tap accumulator
  typedef struct packed {
    logic                 clear;
    logic                 vld;
    logic [TAP_IDX_W-1:0] tap;
  } mac_ctrl_t;

  // q1.15 tap gains, taps past the fifth carry no weight
  function automatic logic [GAIN_W-1:0] tap_gain(input logic [TAP_IDX_W-1:0] t);
    logic [GAIN_W-1:0] g;
    case (t)
      3'd0:    g = 16'd11469;
      3'd1:    g = 16'd8192;
      3'd2:    g = 16'd5898;
      3'd3:    g = 16'd3932;
      3'd4:    g = 16'd2621;
      default: g = 16'd0;
    endcase
    return g;
  endfunction

endpackage

// ----- src/smrd_ram.sv -----
// smrd_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing

module smrd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/smrd_regs.sv -----
// smrd_regs: apb register block holding the enable bit and the five tap delays
// depends on smrd_pkg

module smrd_regs
  import smrd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic       wr;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable   <= 1'b0;
      cfg.delay[0] <= DELAY_ONE_RST;
      cfg.delay[1] <= DELAY_TWO_RST;
      cfg.delay[2] <= DELAY_THREE_RST;
      cfg.delay[3] <= DELAY_FOUR_RST;
      cfg.delay[4] <= DELAY_FIVE_RST;
    end else if (wr) begin
      case (idx)
        REG_ENABLE:      cfg.enable   <= pwdata[0];
        REG_DELAY_ONE:   cfg.delay[0] <= pwdata[DELAY_W-1:0];
        REG_DELAY_TWO:   cfg.delay[1] <= pwdata[DELAY_W-1:0];
        REG_DELAY_THREE: cfg.delay[2] <= pwdata[DELAY_W-1:0];
        REG_DELAY_FOUR:  cfg.delay[3] <= pwdata[DELAY_W-1:0];
        REG_DELAY_FIVE:  cfg.delay[4] <= pwdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_ENABLE:      prdata = {{(PDATA_W-1){1'b0}}, cfg.enable};
      REG_DELAY_ONE:   prdata = {{(PDATA_W-DELAY_W){1'b0}}, cfg.delay[0]};
      REG_DELAY_TWO:   prdata = {{(PDATA_W-DELAY_W){1'b0}}, cfg.delay[1]};
      REG_DELAY_THREE: prdata = {{(PDATA_W-DELAY_W){1'b0}}, cfg.delay[2]};
      REG_DELAY_FOUR:  prdata = {{(PDATA_W-DELAY_W){1'b0}}, cfg.delay[3]};
      REG_DELAY_FIVE:  prdata = {{(PDATA_W-DELAY_W){1'b0}}, cfg.delay[4]};
      default:         prdata = '0;
    endcase
  end

endmodule

// ----- src/smrd_mac.sv -----
// smrd_mac: one channel's tap multiply-accumulate with round and saturate
// depends on smrd_pkg

module smrd_mac
  import smrd_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mac_ctrl_t                      ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic                           busy,
  output logic signed [SAMPLE_WIDTH-1:0] result
);

  localparam int PROD_W = SAMPLE_WIDTH + GAIN_W + 1;
  localparam int ACC_W  = PROD_W + 3;
  localparam int Q_W    = ACC_W + 1 - FRAC_W;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W:0]    rnd;
  logic signed [Q_W-1:0]    q;
  logic                     q_fits;

  assign busy = prod_vld;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctrl.vld;
    end
    prod <= sample * $signed({1'b0, tap_gain(ctrl.tap)});
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  // round half up then saturate
  assign rnd    = {acc[ACC_W-1], acc} + (ACC_W+1)'(1 << (FRAC_W-1));
  assign q      = rnd[ACC_W:FRAC_W];
  assign q_fits = (q[Q_W-1:SAMPLE_WIDTH-1] == '0) || (q[Q_W-1:SAMPLE_WIDTH-1] == '1);

  always_comb begin
    if (q_fits) begin
      result = q[SAMPLE_WIDTH-1:0];
    end else if (q[Q_W-1]) begin
      result = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    end else begin
      result = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end
  end

endmodule

// ----- src/stereo_multitap_reflection_delay_core.sv -----
// stereo_multitap_reflection_delay_core: top level, sequencer, frame store and write pointer
// depends on smrd_pkg, smrd_regs, smrd_ram, smrd_mac
// one word in flight: a new word is accepted only once the previous one has been loaded into the
// output register; when enabled, each word reads the store once per tap,
// and a stalled output holds the input off
// reset: synchronous; clears control, registers, then zeroes every store entry, one entry per cycle;
// no word is accepted during this clearing pass

module stereo_multitap_reflection_delay_core
  import smrd_pkg::*;
#(
  parameter int STORE_DEPTH  = 1024,
  parameter int TAP_COUNT    = 5,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               s_tvalid,
  output logic               s_tready,
  // left_in, right_in
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic               m_tvalid,
  input  logic               m_tready,
  // left_dry, right_dry, left_reflection, right_reflection
  output logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata
);

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int SW    = SAMPLE_WIDTH;
  localparam int OUT_W = ((4*SW+7)/8)*8;
  localparam int TAP_W = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  // delay modulo store depth by conditional subtraction of scaled depths
  function automatic logic [AW-1:0] mod_depth(input logic [DELAY_W-1:0] d);
    logic [DELAY_W-1:0] rem;
    rem = d;
    for (int k = 7; k >= 0; k--) begin
      if ((STORE_DEPTH << k) < (1 << DELAY_W)) begin
        if (rem >= DELAY_W'(STORE_DEPTH << k)) begin
          rem = rem - DELAY_W'(STORE_DEPTH << k);
        end
      end
    end
    return AW'(rem);
  endfunction

  cfg_t                 cfg;
  state_t               state;
  state_t               state_next;
  logic                 clr_active;
  logic [AW-1:0]        clr_addr;
  logic [AW-1:0]        wp;
  logic [TAP_W-1:0]     cnt;
  logic                 rd_vld;
  logic [TAP_IDX_W-1:0] rd_tap;
  logic                 en_item;
  logic [SW-1:0]        left_q;
  logic [SW-1:0]        right_q;
  logic                 s_accept;
  logic                 out_load;
  logic                 issue;
  logic [DELAY_W-1:0]   dly;
  logic [AW-1:0]        dly_mod;
  logic [AW:0]          rp_wrap;
  logic [AW-1:0]        rp;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [2*SW-1:0]      ram_wdata;
  logic [2*SW-1:0]      ram_rdata;
  logic                 mac_busy_l;
  logic                 mac_busy_r;
  logic signed [SW-1:0] refl_l;
  logic signed [SW-1:0] refl_r;
  mac_ctrl_t            mac_ctrl;

  // configuration registers
  smrd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake decode
  assign s_tready = (state == S_IDLE) && !clr_active;
  assign s_accept = s_tvalid && s_tready;
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);
  assign issue    = (state == S_READ);

  // tap address: delay behind the write position
  assign dly     = (32'(cnt) < CFG_TAPS) ? cfg.delay[3'(cnt)] : '0;
  assign dly_mod = mod_depth(dly);
  assign rp_wrap = {1'b0, wp} + (AW+1)'(STORE_DEPTH) - {1'b0, dly_mod};
  assign rp      = (wp >= dly_mod) ? (wp - dly_mod) : rp_wrap[AW-1:0];

  // store write: clearing pass or the accepted frame when enabled
  always_comb begin
    if (clr_active) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = s_accept && cfg.enable;
      ram_waddr = wp;
      ram_wdata = s_tdata[2*SW-1:0];
    end
  end

  smrd_ram #(
    .WIDTH (2*SW),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rp),
    .rdata (ram_rdata)
  );

  // accumulators, one per channel
  assign mac_ctrl.clear = s_accept;
  assign mac_ctrl.vld   = rd_vld;
  assign mac_ctrl.tap   = rd_tap;

  smrd_mac #(.SAMPLE_WIDTH(SW)) u_mac_l (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .sample (ram_rdata[SW-1:0]),
    .busy   (mac_busy_l),
    .result (refl_l)
  );

  smrd_mac #(.SAMPLE_WIDTH(SW)) u_mac_r (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .sample (ram_rdata[2*SW-1:SW]),
    .busy   (mac_busy_r),
    .result (refl_r)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_accept) begin
          state_next = cfg.enable ? S_READ : S_DONE;
        end
      end
      S_READ: begin
        if (cnt == TAP_W'(TAP_COUNT-1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_vld && !mac_busy_l && !mac_busy_r) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      clr_active <= 1'b1;
      clr_addr   <= '0;
      wp         <= '0;
      cnt        <= '0;
      rd_vld     <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;
      if (clr_active) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(STORE_DEPTH-1)) begin
          clr_active <= 1'b0;
        end
      end
      if (s_accept) begin
        cnt <= '0;
      end else if (issue) begin
        cnt <= cnt + 1'b1;
      end
      if (out_load && en_item) begin
        wp <= (wp == AW'(STORE_DEPTH-1)) ? '0 : wp + 1'b1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_tap <= TAP_IDX_W'(cnt);
    if (s_accept) begin
      left_q  <= s_tdata[SW-1:0];
      right_q <= s_tdata[2*SW-1:SW];
      en_item <= cfg.enable;
    end
    if (out_load) begin
      m_tdata <= OUT_W'({(en_item ? refl_r : {SW{1'b0}}),
                         (en_item ? refl_l : {SW{1'b0}}),
                         right_q, left_q});
    end
  end

  // checks
  a_wp_moves_on_load: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (wp != $past(wp))) |-> $past(out_load && en_item))
    else $error("write pointer moved without an enabled word leaving");

  a_read_from_seq: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && rd_vld) |-> $past(state == S_READ))
    else $error("tap read valid outside the read phase");

  a_one_word_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> !s_tready)
    else $error("second word accepted before the first finished");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> ((state == S_IDLE) && !m_tvalid))
    else $error("work started during the store clearing pass");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// testbench for stereo_multitap_reflection_delay_core: streams stereo frames through the core
// and checks every output word against a tap-sum predictor; depends on smrd_pkg and the core

module testbench
  import smrd_pkg::*;
();

  localparam int SAMPLE_W    = 24;
  localparam int IN_W        = ((2*SAMPLE_W+7)/8)*8;
  localparam int OUT_W       = ((4*SAMPLE_W+7)/8)*8;
  localparam int SLOTS       = 1024;
  localparam int TAPS        = 5;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_PAUSE = 16;
  localparam int HOLD_AFTER  = 150;
  localparam int HOLD_CYCLES = 600;
  localparam int PHASE_WORDS = 265;
  localparam int PHASES      = 6;
  localparam longint SAMPLE_HI = 64'sd8388607;
  localparam longint SAMPLE_LO = -64'sd8388608;

  // register slots past the map, writes there must change nothing
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  // one output word, last field in the lowest bits
  typedef struct packed {
    logic [SAMPLE_W-1:0] right_refl;
    logic [SAMPLE_W-1:0] left_refl;
    logic [SAMPLE_W-1:0] right_dry;
    logic [SAMPLE_W-1:0] left_dry;
  } echo_frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic s_tvalid = 1'b0;
  logic s_tready;
  // left_in, right_in
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  // left_dry, right_dry, left_reflection, right_reflection
  logic [OUT_W-1:0] m_tdata;

  // stimulus and expectation stores
  logic [IN_W-1:0] frame_queue[$];
  echo_frame_t expected_q[$];

  // predictor state: delay store, write pointer, live configuration
  logic [SAMPLE_W-1:0] echo_left [SLOTS];
  logic [SAMPLE_W-1:0] echo_right [SLOTS];
  logic [9:0] echo_wr_ptr;
  logic echo_on;
  logic [DELAY_W-1:0] echo_delay [TAPS];

  logic steady_flow = 1'b0;
  logic receiver_hold = 1'b0;
  int accepted_count = 0;
  int checked_count = 0;
  int fail_count = 0;
  int settings_count = 0;
  int reads_checked = 0;

  stereo_multitap_reflection_delay_core DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // q1.15 weight of each tap
  function automatic longint tap_weight(input int t);
    case (t)
      0:       return 64'sd11469;
      1:       return 64'sd8192;
      2:       return 64'sd5898;
      3:       return 64'sd3932;
      4:       return 64'sd2621;
      default: return 64'sd0;
    endcase
  endfunction

  // round half up out of q15, then clip to the sample range
  function automatic logic [SAMPLE_W-1:0] round_clip(input longint acc);
    longint q;
    q = (acc + 64'sd16384) >>> 15;
    if (q > SAMPLE_HI) return 24'h7FFFFF;
    if (q < SAMPLE_LO) return 24'h800000;
    return q[SAMPLE_W-1:0];
  endfunction

  // when enabled: write the frame, sum the five weighted taps, advance the pointer
  function automatic echo_frame_t reflect_frame(input logic [SAMPLE_W-1:0] left_in,
                                                input logic [SAMPLE_W-1:0] right_in);
    echo_frame_t res;
    longint acc_left;
    longint acc_right;
    logic [9:0] rd;
    res.left_dry   = left_in;
    res.right_dry  = right_in;
    res.left_refl  = '0;
    res.right_refl = '0;
    if (echo_on) begin
      echo_left[echo_wr_ptr]  = left_in;
      echo_right[echo_wr_ptr] = right_in;
      acc_left  = 0;
      acc_right = 0;
      for (int t = 0; t < TAPS; t++) begin
        rd = echo_wr_ptr - echo_delay[t];
        acc_left  += longint'($signed(echo_left[rd])) * tap_weight(t);
        acc_right += longint'($signed(echo_right[rd])) * tap_weight(t);
      end
      res.left_refl  = round_clip(acc_left);
      res.right_refl = round_clip(acc_right);
      echo_wr_ptr = echo_wr_ptr + 10'd1;
    end
    return res;
  endfunction

  // random idle decision shared by both sides
  function automatic bit take_break();
    return !steady_flow && ($urandom_range(99) < 8);
  endfunction

  // sample values weighted toward the extremes
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2:       return 24'(int'($urandom_range(255)) - 128);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [DELAY_W-1:0] pick_delay();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 10'd1023;
      2:       return 10'd1;
      3:       return 10'($urandom_range(16, 1));
      default: return 10'($urandom_range(1023));
    endcase
  endfunction

  task automatic send_frame(input logic [SAMPLE_W-1:0] left_in,
                            input logic [SAMPLE_W-1:0] right_in);
    frame_queue.push_back({right_in, left_in});
  endtask

  // apb write, setup then access, shadow follows the register rules
  task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_ENABLE) echo_on = value[0];
    else if (idx <= REG_DELAY_FIVE) echo_delay[idx - REG_DELAY_ONE] = value[DELAY_W-1:0];
  endtask

  // apb read, compared with the shadow copy
  task automatic read_reg(input logic [2:0] idx);
    logic [PDATA_W-1:0] want;
    want = (idx == REG_ENABLE) ? PDATA_W'(echo_on)
                               : PDATA_W'(echo_delay[idx - REG_DELAY_ONE]);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    reads_checked++;
    if (prdata !== want) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("register %0d read back %h, expected %h", idx, prdata, want);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_all_regs();
    read_reg(REG_ENABLE);
    read_reg(REG_DELAY_ONE);
    read_reg(REG_DELAY_TWO);
    read_reg(REG_DELAY_THREE);
    read_reg(REG_DELAY_FOUR);
    read_reg(REG_DELAY_FIVE);
  endtask

  // every frame sent and every word back, then a short settle
  task automatic wait_idle();
    do @(posedge clk);
    while (frame_queue.size() != 0 || s_tvalid || expected_q.size() != 0);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  // input driver, next word loaded once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (frame_queue.size() != 0 && !take_break()) begin
        s_tvalid <= 1'b1;
        s_tdata  <= frame_queue.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // prediction on every accepted input word
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      expected_q.push_back(reflect_frame(s_tdata[SAMPLE_W-1:0], s_tdata[2*SAMPLE_W-1:SAMPLE_W]));
      accepted_count++;
    end
  end

  // output back-pressure
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= !receiver_hold && !take_break();
  end

  // output monitor
  always @(posedge clk) begin : check_output
    echo_frame_t want;
    echo_frame_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      checked_count++;
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("output word %h with nothing expected", m_tdata);
      end else begin
        want = expected_q.pop_front();
        if (got.left_dry !== want.left_dry || got.right_dry !== want.right_dry ||
            got.left_refl !== want.left_refl || got.right_refl !== want.right_refl) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("word %0d: expected dry %0d %0d refl %0d %0d, got dry %0d %0d refl %0d %0d",
                     checked_count,
                     $signed(want.left_dry), $signed(want.right_dry),
                     $signed(want.left_refl), $signed(want.right_refl),
                     $signed(got.left_dry), $signed(got.right_dry),
                     $signed(got.left_refl), $signed(got.right_refl));
        end
      end
    end
  end

  // long receiver stall while the sender keeps offering
  initial begin
    wait (accepted_count >= HOLD_AFTER);
    @(posedge clk);
    receiver_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    receiver_hold <= 1'b0;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // stimulus
  initial begin
    logic [PDATA_W-1:0] en_word;
    for (int i = 0; i < SLOTS; i++) begin
      echo_left[i]  = '0;
      echo_right[i] = '0;
    end
    echo_wr_ptr   = '0;
    echo_on       = 1'b0;
    echo_delay[0] = DELAY_ONE_RST;
    echo_delay[1] = DELAY_TWO_RST;
    echo_delay[2] = DELAY_THREE_RST;
    echo_delay[3] = DELAY_FOUR_RST;
    echo_delay[4] = DELAY_FIVE_RST;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    read_all_regs();

    // disabled after reset: dry pass-through, zero reflections
    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(24'h800000, 24'h7FFFFF);
    send_frame(24'h000000, 24'hFFFFFF);
    send_frame(24'h555555, 24'hAAAAAA);
    wait_idle();

    // enabled with reset delays, store reads zero at first
    write_reg(REG_ENABLE, 32'hFFFF_FFFF);
    settings_count++;
    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(24'h000000, 24'h000000);
    send_frame(24'h000000, 24'h000000);
    send_frame(24'h000000, 24'h000000);
    send_frame(24'h800000, 24'h7FFFFF);
    send_frame(24'hFFFFFF, 24'h000001);
    wait_idle();

    // zero delay, largest delay, upper bits masked, spare slots ignored
    write_reg(REG_DELAY_ONE, 32'h0000_0000);
    write_reg(REG_DELAY_TWO, 32'hFFFF_FFFF);
    write_reg(REG_DELAY_THREE, 32'h0000_0001);
    write_reg(REG_DELAY_FOUR, 32'hABCD_E802);
    write_reg(REG_DELAY_FIVE, 32'h0000_03FF);
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'h0000_0000);
    settings_count++;
    read_all_regs();
    send_frame(24'h7FFFFF, 24'h7FFFFF);
    send_frame(24'h800000, 24'h800000);
    send_frame(24'h000001, 24'hFFFFFF);
    send_frame(pick_sample(), pick_sample());
    send_frame(24'h000000, 24'h000000);
    wait_idle();

    // disabled again holds the pointer, then resume
    write_reg(REG_ENABLE, 32'hFFFF_FFFE);
    send_frame(24'h123456, 24'hEDCBA9);
    send_frame(24'h7FFFFF, 24'h800000);
    wait_idle();
    write_reg(REG_ENABLE, 32'h0000_0001);
    settings_count++;
    send_frame(24'h3FFFFF, 24'hC00000);
    send_frame(24'h000000, 24'h000000);
    wait_idle();

    // random phases over several register settings
    for (int ph = 0; ph < PHASES; ph++) begin
      @(posedge clk);
      steady_flow <= (ph == 1);
      en_word = ($urandom & 32'hFFFF_FFFE) | PDATA_W'(ph != 3);
      write_reg(REG_ENABLE, en_word);
      write_reg(REG_DELAY_ONE, ($urandom << DELAY_W) |
                (ph == 2 ? 32'd0 : ph == 5 ? 32'd1023 : PDATA_W'(pick_delay())));
      write_reg(REG_DELAY_TWO, ($urandom << DELAY_W) |
                (ph == 2 ? 32'd0 : ph == 5 ? 32'd1023 : PDATA_W'(pick_delay())));
      write_reg(REG_DELAY_THREE, ($urandom << DELAY_W) |
                (ph == 2 ? 32'd0 : ph == 5 ? 32'd1023 : PDATA_W'(pick_delay())));
      write_reg(REG_DELAY_FOUR, ($urandom << DELAY_W) |
                (ph == 2 ? 32'd0 : ph == 5 ? 32'd1023 : PDATA_W'(pick_delay())));
      write_reg(REG_DELAY_FIVE, ($urandom << DELAY_W) |
                (ph == 2 ? 32'd0 : ph == 5 ? 32'd1023 : PDATA_W'(pick_delay())));
      settings_count++;
      read_all_regs();
      for (int n = 0; n < PHASE_WORDS; n++) send_frame(pick_sample(), pick_sample());
      wait_idle();
    end

    $display("covered %0d frames and %0d output words over %0d register settings",
             accepted_count, checked_count, settings_count);
    $display("%0d register reads checked, one receiver stall of %0d cycles",
             reads_checked, HOLD_CYCLES);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
